// ----- design/shns_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shns_pkg
// Shared types and constants of the spatial hash neighbor search block.
// ---------------------------------------------------------------------------
package shns_pkg;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic REG_CELL_EDGE = 1'b0;

  localparam logic [31:0] HASH_MUL_X = 32'd92837111;
  localparam logic [31:0] HASH_MUL_Y = 32'd689287499;

  localparam logic [30:0] CELL_EDGE_RESET = 31'd65536;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        particle_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } shns_in_t;

  typedef struct packed {
    logic [11:0] neighbour_index;
    logic        valid_res;
    logic        overflow;
    logic        last;
  } shns_out_t;

  typedef struct packed {
    logic [15:0] mark;
    logic [11:0] head;
  } shns_bkt_t;

endpackage

// ----- design/shns_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shns_div
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module shns_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dsr;
  logic [31:0] remainder;
  logic [32:0] trial;

  assign trial = {remainder, quotient[31]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        dsr       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          remainder <= trial[31:0];
          quotient  <= {quotient[30:0], 1'b1};
        end else begin
          remainder <= {remainder[30:0], quotient[31]};
          quotient  <= {quotient[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/spatial_hash_neighbour_search_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spatial_hash_neighbour_search_top
// Spatial hash grid: begin frame, insert particle, query 3x3 neighborhood.
// ---------------------------------------------------------------------------
// One item is in work at a time. After reset, and after a begin frame that
// wraps the frame mark, a clearing pass sweeps every bucket of the bucket
// memory and no beat is taken. An insert runs the two position divides on
// the shared serial divider, then hashes its cell (with an extra remainder
// step when NUM_BUCKETS is not a power of two), reads the bucket and links
// the particle in. A query runs the same divides, then for each searched
// cell hashes it (with the same remainder step for a non power-of-two
// table), reads its bucket and walks its chain one particle at a time,
// then drains the result buffer one beat per result, at least one beat.
// The serial divider and the one read port of each memory set this pace.
module spatial_hash_neighbour_search_top #(
  parameter int NUM_BUCKETS    = 4096,
  parameter int MAX_PARTICLES  = 4096,
  parameter int MAX_NEIGHBOURS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire shns_pkg::shns_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output shns_pkg::shns_out_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import shns_pkg::*;

  localparam int TW       = $clog2(NUM_BUCKETS);
  localparam int CN_DEPTH = (MAX_PARTICLES < 4096) ? MAX_PARTICLES : 4096;
  localparam int CW       = (CN_DEPTH > 1) ? $clog2(CN_DEPTH) : 1;
  localparam int BW       = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int CNTW     = $clog2(MAX_NEIGHBOURS + 1);
  localparam bit TS_POW2  = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
  localparam logic [32:0] RECIP =
    33'(((64'd1 << (32 + TW)) / 64'(NUM_BUCKETS)) + 64'd1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_XS    = 4'd2;
  localparam logic [3:0] S_XW    = 4'd3;
  localparam logic [3:0] S_YW    = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_HASH  = 4'd6;
  localparam logic [3:0] S_MOD   = 4'd7;
  localparam logic [3:0] S_BRD   = 4'd8;
  localparam logic [3:0] S_BCHK  = 4'd9;
  localparam logic [3:0] S_WALK  = 4'd10;
  localparam logic [3:0] S_CHAIN = 4'd11;
  localparam logic [3:0] S_DRAIN = 4'd12;
  localparam logic [3:0] S_DRD   = 4'd13;
  localparam logic [3:0] S_DLD   = 4'd14;
  localparam logic [3:0] S_DWAIT = 4'd15;

  logic [3:0]      state;
  logic [30:0]     cell_edge;
  logic [15:0]     frame_mark;
  logic [TW-1:0]   clr_addr;
  shns_in_t        in_q;
  logic [31:0]     cx;
  logic [31:0]     cy;
  logic [1:0]      dx;
  logic [1:0]      dy;
  logic [31:0]     hx;
  logic [31:0]     hy;
  logic [TW-1:0]   bkt;
  logic [11:0]     j;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] rd_ptr;
  logic            cut;
  logic [64:0]     rprod;

  shns_bkt_t       bucket_mem [NUM_BUCKETS];
  shns_bkt_t       bucket_q;
  logic [12:0]     chain_mem [CN_DEPTH];
  logic [12:0]     chain_q;
  logic [11:0]     rbuf [MAX_NEIGHBOURS];
  logic [11:0]     rbuf_q;

  logic            b_we;
  logic [TW-1:0]   b_waddr;
  shns_bkt_t       b_wdata;
  logic            c_we;
  logic [12:0]     c_wdata;
  logic            r_we;

  logic            div_start;
  logic [31:0]     div_a;
  logic [31:0]     div_b;
  logic            div_done;
  logic [31:0]     div_quo;

  logic [31:0]     cs_eff;
  logic [31:0]     px_mag;
  logic [31:0]     py_mag;
  logic [31:0]     quo_signed;
  logic [31:0]     xs;
  logic [31:0]     ys;
  logic [31:0]     hv;
  logic [31:0]     mag;
  logic [31:0]     rquo;
  logic [31:0]     rrem;
  logic            live;
  logic            j_ok;
  logic            last_cell;
  logic            pidx_ok;
  logic            cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (paddr[2] == REG_CELL_EDGE) ? {1'b0, cell_edge} : 32'd0;
  assign cs_eff  = (cell_edge == 31'd0) ? 32'd1 : {1'b0, cell_edge};
  assign in_ready = (state == S_IDLE);

  assign px_mag = in_q.pos_x[31] ? (~in_q.pos_x + 32'd1) : in_q.pos_x;
  assign py_mag = in_q.pos_y[31] ? (~in_q.pos_y + 32'd1) : in_q.pos_y;
  assign quo_signed = ((state == S_XW) ? in_q.pos_x[31] : in_q.pos_y[31]) ?
                      (~div_quo + 32'd1) : div_quo;

  assign xs  = cx + 32'(dx) - 32'd1;
  assign ys  = cy + 32'(dy) - 32'd1;
  assign hv  = hx ^ hy;
  assign mag = hv[31] ? (~hv + 32'd1) : hv;

  assign rquo = 32'(rprod >> (32 + TW));
  assign rrem = mag - rquo * 32'(NUM_BUCKETS);

  assign live      = (bucket_q.mark == frame_mark);
  assign j_ok      = ({20'd0, j} < 32'(MAX_PARTICLES));
  assign last_cell = (dx == 2'd2) && (dy == 2'd2);
  assign pidx_ok   = ({20'd0, in_data.particle_index} < 32'(MAX_PARTICLES));

  always_comb begin
    div_start = 1'b0;
    div_a     = px_mag;
    div_b     = cs_eff;
    case (state)
      S_XS: begin
        div_start = 1'b1;
      end
      S_XW: begin
        div_start = div_done;
        div_a     = py_mag;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  shns_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_quo)
  );

  always_comb begin
    b_we    = 1'b0;
    b_waddr = bkt;
    b_wdata = '{mark: frame_mark, head: in_q.particle_index};
    c_we    = 1'b0;
    c_wdata = live ? {1'b1, bucket_q.head} : 13'd0;
    r_we    = 1'b0;
    case (state)
      S_CLR: begin
        b_we    = 1'b1;
        b_waddr = clr_addr;
        b_wdata = '0;
      end
      S_BCHK: begin
        b_we = (in_q.op == OP_INSERT);
        c_we = (in_q.op == OP_INSERT);
      end
      S_WALK: begin
        r_we = j_ok && (count != CNTW'(MAX_NEIGHBOURS));
      end
      default: begin
        b_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bucket_mem[b_waddr] <= b_wdata;
    end
    bucket_q <= bucket_mem[bkt];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      chain_mem[in_q.particle_index[CW-1:0]] <= c_wdata;
    end
    chain_q <= chain_mem[j[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rbuf[count[BW-1:0]] <= j;
    end
    rbuf_q <= rbuf[rd_ptr[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_edge <= CELL_EDGE_RESET;
    end else if (cfg_wr && paddr[2] == REG_CELL_EDGE) begin
      cell_edge <= pwdata[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      frame_mark <= '0;
      out_valid  <= 1'b0;
      count      <= '0;
      rd_ptr     <= '0;
      cut        <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + TW'(1);
          if (clr_addr == TW'(NUM_BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            in_q <= in_data;
            case (in_data.op)
              OP_BEGIN: begin
                if (frame_mark == 16'hFFFF) begin
                  frame_mark <= 16'd1;
                  clr_addr   <= '0;
                  state      <= S_CLR;
                end else begin
                  frame_mark <= frame_mark + 16'd1;
                end
              end
              OP_INSERT: begin
                if (frame_mark != 16'd0 && pidx_ok) begin
                  state <= S_XS;
                end
              end
              OP_QUERY: begin
                count <= '0;
                cut   <= 1'b0;
                state <= S_XS;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_XS: begin
          state <= S_XW;
        end
        S_XW: begin
          if (div_done) begin
            cx    <= quo_signed;
            state <= S_YW;
          end
        end
        S_YW: begin
          if (div_done) begin
            cy    <= quo_signed;
            dx    <= (in_q.op == OP_QUERY) ? 2'd0 : 2'd1;
            dy    <= (in_q.op == OP_QUERY) ? 2'd0 : 2'd1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          hx    <= xs * HASH_MUL_X;
          hy    <= ys * HASH_MUL_Y;
          state <= S_HASH;
        end
        S_HASH: begin
          if (TS_POW2) begin
            bkt   <= mag[TW-1:0];
            state <= S_BRD;
          end else begin
            rprod <= 65'(mag) * 65'(RECIP);
            state <= S_MOD;
          end
        end
        S_MOD: begin
          bkt   <= rrem[TW-1:0];
          state <= S_BRD;
        end
        S_BRD: begin
          state <= S_BCHK;
        end
        S_BCHK: begin
          if (in_q.op == OP_INSERT) begin
            state <= S_IDLE;
          end else if (frame_mark != 16'd0 && live) begin
            j     <= bucket_q.head;
            state <= S_WALK;
          end else if (last_cell) begin
            state <= S_DRAIN;
          end else begin
            if (dy == 2'd2) begin
              dx <= dx + 2'd1;
              dy <= 2'd0;
            end else begin
              dy <= dy + 2'd1;
            end
            state <= S_MUL;
          end
        end
        S_WALK: begin
          if (!j_ok) begin
            if (last_cell) begin
              state <= S_DRAIN;
            end else begin
              if (dy == 2'd2) begin
                dx <= dx + 2'd1;
                dy <= 2'd0;
              end else begin
                dy <= dy + 2'd1;
              end
              state <= S_MUL;
            end
          end else if (count == CNTW'(MAX_NEIGHBOURS)) begin
            cut   <= 1'b1;
            state <= S_DRAIN;
          end else begin
            count <= count + CNTW'(1);
            state <= S_CHAIN;
          end
        end
        S_CHAIN: begin
          if (chain_q[12]) begin
            j     <= chain_q[11:0];
            state <= S_WALK;
          end else if (last_cell) begin
            state <= S_DRAIN;
          end else begin
            if (dy == 2'd2) begin
              dx <= dx + 2'd1;
              dy <= 2'd0;
            end else begin
              dy <= dy + 2'd1;
            end
            state <= S_MUL;
          end
        end
        S_DRAIN: begin
          rd_ptr <= '0;
          if (count == '0) begin
            out_data  <= '{neighbour_index: 12'd0, valid_res: 1'b0,
                           overflow: 1'b0, last: 1'b1};
            out_valid <= 1'b1;
            state     <= S_DWAIT;
          end else begin
            state <= S_DRD;
          end
        end
        S_DRD: begin
          state <= S_DLD;
        end
        S_DLD: begin
          out_data  <= '{neighbour_index: rbuf_q, valid_res: 1'b1, overflow: cut,
                         last: (rd_ptr == count - CNTW'(1))};
          out_valid <= 1'b1;
          state     <= S_DWAIT;
        end
        S_DWAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_data.last) begin
              state <= S_IDLE;
            end else begin
              rd_ptr <= rd_ptr + CNTW'(1);
              state  <= S_DRD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_DWAIT))
    else $error("result beat shown outside the drain wait");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while a result beat is pending");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_NEIGHBOURS))
    else $error("neighbor count above cap");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> (state == S_IDLE))
    else $error("query did not finish after its last beat");
`endif

endmodule
`default_nettype wire
